// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the lexer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lexer assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lexer assertion failed");

`else

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/ctl_pkg.sv =====
package ctl_pkg;

	localparam int COUNTER_WIDTH_DEF = 16;
	localparam int FIFO_DEPTH        = 4;
	localparam int PTR_W             = $clog2(FIFO_DEPTH);

	// character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	// keyword tracker codes
	localparam logic [3:0] KW_NONE   = 4'd0;
	localparam logic [3:0] KW_R      = 4'd1;
	localparam logic [3:0] KW_RETURN = 4'd6;
	localparam logic [3:0] KW_I      = 4'd7;
	localparam logic [3:0] KW_INT    = 4'd9;
	localparam logic [3:0] KW_C      = 4'd10;
	localparam logic [3:0] KW_CHAR   = 4'd13;

	typedef enum logic [4:0] {
		K_END    = 5'd0,
		K_RETURN = 5'd1,
		K_INT    = 5'd2,
		K_CHAR   = 5'd3,
		K_ID     = 5'd4,
		K_NUM    = 5'd5,
		K_STR    = 5'd6,
		K_PLUS   = 5'd7,
		K_MINUS  = 5'd8,
		K_EQ     = 5'd9,
		K_LPAR   = 5'd10,
		K_RPAR   = 5'd11,
		K_LBRACE = 5'd12,
		K_RBRACE = 5'd13,
		K_COMMA  = 5'd14,
		K_SEMI   = 5'd15,
		K_ERR    = 5'd16
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] line;
		logic [15:0] col;
		logic [15:0] len;
		logic        last;
	} result_t;

	typedef struct packed {
		logic    v0;
		logic    v1;
		result_t r0;
		result_t r1;
	} step_out_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	// symbol kind, K_ERR when the byte is no symbol
	function automatic kind_t sym_kind(input logic [7:0] c);
		kind_t k;
		k = K_ERR;
		case (c)
			"+":     k = K_PLUS;
			"-":     k = K_MINUS;
			"=":     k = K_EQ;
			"(":     k = K_LPAR;
			")":     k = K_RPAR;
			"{":     k = K_LBRACE;
			"}":     k = K_RBRACE;
			",":     k = K_COMMA;
			";":     k = K_SEMI;
			default: k = K_ERR;
		endcase
		return k;
	endfunction

	function automatic logic is_term(input logic [7:0] c);
		return c == CH_NUL || c == CH_QUOTE || c == CH_SLASH || is_space(c)
			|| sym_kind(c) != K_ERR;
	endfunction

	// next expected keyword letter, zero when none
	function automatic logic [7:0] kw_next(input logic [3:0] k);
		logic [7:0] n;
		n = 8'h00;
		case (k)
			4'd1:    n = "e";
			4'd2:    n = "t";
			4'd3:    n = "u";
			4'd4:    n = "r";
			4'd5:    n = "n";
			4'd7:    n = "n";
			4'd8:    n = "t";
			4'd10:   n = "h";
			4'd11:   n = "a";
			4'd12:   n = "r";
			default: n = 8'h00;
		endcase
		return n;
	endfunction

	function automatic logic [15:0] clamp16(input logic [31:0] v);
		return (|v[31:16]) ? 16'hFFFF : v[15:0];
	endfunction

endpackage

// ===== rtl/ctl_lex_core.sv =====
`include "assert_macros.svh"

module ctl_lex_core
	import ctl_pkg::*;
#(
	parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] byte_s1,
	output step_out_t  res
);

	localparam int CW = COUNTER_WIDTH;

	typedef enum logic [2:0] {
		M_IDLE, M_IDENT, M_ZERO, M_NUM, M_LEADZ, M_JUNK, M_STRING, M_STRAY
	} mode_t;

	mode_t          mode_q, mode_n;
	logic [3:0]     kw_q, kw_n;
	logic           letters_q, letters_n;
	logic [CW-1:0]  line_q, line_n;
	logic [CW-1:0]  col_q, col_n;
	logic [CW-1:0]  tstart_q, tstart_n;
	logic [CW-1:0]  tlen_q, tlen_n;

	logic           close, consumed, idle_emit;
	kind_t          pkind, ikind;
	logic [CW-1:0]  plen;
	logic [CW-1:0]  icol;
	logic [15:0]    ilen;
	logic [7:0]     kw_exp;

	function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
		return (&v) ? v : CW'(v + 1'b1);
	endfunction

	function automatic kind_t ident_kind(input logic [3:0] k, input logic letters);
		kind_t r;
		if (k == KW_RETURN)
			r = K_RETURN;
		else if (k == KW_INT)
			r = K_INT;
		else if (k == KW_CHAR)
			r = K_CHAR;
		else
			r = letters ? K_ID : K_ERR;
		return r;
	endfunction

	always_comb begin
		mode_n    = mode_q;
		kw_n      = kw_q;
		letters_n = letters_q;
		line_n    = line_q;
		col_n     = (byte_s1 != CH_NUL) ? sat_inc(col_q) : col_q;
		tstart_n  = tstart_q;
		tlen_n    = tlen_q;
		close     = 1'b0;
		consumed  = 1'b1;
		pkind     = K_ERR;
		plen      = tlen_q;
		idle_emit = 1'b0;
		ikind     = K_END;
		ilen      = 16'd1;
		icol      = col_q;
		kw_exp    = kw_next(kw_q);

		// pending token
		case (mode_q)
			M_IDENT: begin
				if (is_term(byte_s1)) begin
					close    = 1'b1;
					consumed = 1'b0;
					pkind    = ident_kind(kw_q, letters_q);
				end else begin
					kw_n = (kw_exp != 8'h00 && kw_exp == byte_s1) ? 4'(kw_q + 1'b1) : KW_NONE;
					if (!is_alpha(byte_s1))
						letters_n = 1'b0;
					tlen_n = sat_inc(tlen_q);
				end
			end
			M_ZERO, M_NUM: begin
				if (is_digit(byte_s1)) begin
					if (mode_q == M_ZERO)
						mode_n = M_LEADZ;
					tlen_n = sat_inc(tlen_q);
				end else if (is_term(byte_s1)) begin
					close    = 1'b1;
					consumed = 1'b0;
					pkind    = K_NUM;
				end else begin
					mode_n = M_JUNK;
					tlen_n = sat_inc(tlen_q);
				end
			end
			M_LEADZ: begin
				if (is_digit(byte_s1)) begin
					tlen_n = sat_inc(tlen_q);
				end else begin
					close    = 1'b1;
					consumed = 1'b0;
				end
			end
			M_JUNK, M_STRAY: begin
				if (is_term(byte_s1)) begin
					close    = 1'b1;
					consumed = 1'b0;
				end else begin
					tlen_n = sat_inc(tlen_q);
				end
			end
			M_STRING: begin
				if (byte_s1 == CH_QUOTE) begin
					close = 1'b1;
					pkind = K_STR;
					plen  = sat_inc(tlen_q);
				end else if (byte_s1 == CH_NUL || byte_s1 == CH_NL) begin
					close    = 1'b1;
					consumed = 1'b0;
				end else begin
					tlen_n = sat_inc(tlen_q);
				end
			end
			default: begin
				consumed = 1'b0;
			end
		endcase

		if (close)
			mode_n = M_IDLE;

		// byte seen from idle
		if (!consumed) begin
			if (byte_s1 == CH_NUL) begin
				// end token reports the column before the state clears
				idle_emit = 1'b1;
				ikind     = K_END;
				ilen      = 16'd0;
				mode_n    = M_IDLE;
				kw_n      = KW_NONE;
				letters_n = 1'b1;
				line_n    = CW'(1);
				col_n     = '0;
				tstart_n  = '0;
				tlen_n    = '0;
			end else if (is_space(byte_s1)) begin
				if (byte_s1 == CH_NL) begin
					line_n = sat_inc(line_q);
					col_n  = '0;
				end
			end else if (is_alpha(byte_s1)) begin
				mode_n    = M_IDENT;
				tstart_n  = col_n;
				tlen_n    = CW'(1);
				letters_n = 1'b1;
				kw_n      = (byte_s1 == "r") ? KW_R : (byte_s1 == "i") ? KW_I :
				            (byte_s1 == "c") ? KW_C : KW_NONE;
			end else if (is_digit(byte_s1)) begin
				mode_n   = (byte_s1 == "0") ? M_ZERO : M_NUM;
				tstart_n = col_n;
				tlen_n   = CW'(1);
			end else if (byte_s1 == CH_QUOTE) begin
				mode_n   = M_STRING;
				tstart_n = col_n;
				tlen_n   = CW'(1);
			end else if (sym_kind(byte_s1) != K_ERR) begin
				idle_emit = 1'b1;
				ikind     = sym_kind(byte_s1);
				icol      = col_n;
			end else begin
				mode_n   = M_STRAY;
				tstart_n = col_n;
				tlen_n   = CW'(1);
			end
		end
	end

	// results: the closed token first, then the one the byte makes by itself
	always_comb begin
		result_t pend, idl;
		pend.kind = pkind;
		pend.line = clamp16(32'(line_q));
		pend.col  = clamp16(32'(tstart_q));
		pend.len  = clamp16(32'(plen));
		pend.last = !idle_emit;
		idl.kind  = ikind;
		idl.line  = clamp16(32'(line_q));
		idl.col   = clamp16(32'(icol));
		idl.len   = ilen;
		idl.last  = 1'b1;
		res.v0    = close | idle_emit;
		res.v1    = close & idle_emit;
		res.r0    = close ? pend : idl;
		res.r1    = idl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= M_IDLE;
			kw_q      <= KW_NONE;
			letters_q <= 1'b1;
			line_q    <= CW'(1);
			col_q     <= '0;
			tstart_q  <= '0;
			tlen_q    <= '0;
		end else if (step) begin
			mode_q    <= mode_n;
			kw_q      <= kw_n;
			letters_q <= letters_n;
			line_q    <= line_n;
			col_q     <= col_n;
			tstart_q  <= tstart_n;
			tlen_q    <= tlen_n;
		end
	end

	`ASSERT_NEXT(a_eot_clears, clk, arst_n, step && byte_s1 == CH_NUL, mode_q == M_IDLE && line_q == CW'(1) && col_q == '0)
	`ASSERT_IMP(a_kw_range, clk, arst_n, 1'b1, kw_q <= KW_CHAR)
	`ASSERT_IMP(a_tok_len_set, clk, arst_n, mode_q != M_IDLE, tlen_q != '0)

endmodule

// ===== rtl/c_subset_token_lexer_unit.sv =====
// Streaming lexer for a small C subset. One source byte per item goes in on the
// in_valid/in_stall channel (byte 0 ends the text); every closed token comes out
// on the out_valid/out_stall channel with its kind, start line, start column,
// length and a last_of_run flag that marks the final result of one byte. A byte
// yields zero, one or two results (pending token plus a symbol or end token).
// An accepted byte waits in the input register, and its results are written
// into the four-entry result queue, from which the first is offered. The
// block takes one byte per cycle as long as the queue has room for two results,
// so the rate is one byte per cycle while results are drained at least as fast
// as they are made; the single-result output port cannot keep up with a steady
// run of bytes that close a token and make a symbol. After the end token the
// line/column state returns to its reset values.
`include "assert_macros.svh"

module c_subset_token_lexer_unit
	import ctl_pkg::*;
#(
	parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  byte_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  token_kind,
	output logic [15:0] start_line,
	output logic [15:0] start_column,
	output logic [15:0] token_length,
	output logic        last_of_run
);

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;

	// result queue
	result_t      fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   cnt_q;

	step_out_t   step_res;
	logic        advance;
	logic        in_take;
	logic        pop;
	logic [1:0]  push_n;
	result_t     head;

	// the held byte moves on only when two queue slots are free
	assign advance  = valid_s1 && (cnt_q <= (PTR_W+1)'(FIFO_DEPTH - 2));
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// byte register is payload, no reset
	always_ff @(posedge clk) begin
		if (in_take)
			byte_s1 <= byte_in;
	end

	ctl_lex_core #(
		.COUNTER_WIDTH(COUNTER_WIDTH)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.byte_s1 (byte_s1),
		.res     (step_res)
	);

	// queue bookkeeping
	assign push_n = advance ? (2'(step_res.v0) + 2'(step_res.v1)) : 2'd0;
	assign pop    = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= PTR_W'(wr_ptr_q + push_n);
			rd_ptr_q <= PTR_W'(rd_ptr_q + pop);
			cnt_q    <= (PTR_W+1)'(cnt_q + push_n - pop);
		end
	end

	// queue entries carry payload only
	always_ff @(posedge clk) begin
		if (advance && step_res.v0)
			fifo_q[wr_ptr_q] <= step_res.r0;
		if (advance && step_res.v1)
			fifo_q[PTR_W'(wr_ptr_q + 1'b1)] <= step_res.r1;
	end

	assign head         = fifo_q[rd_ptr_q];
	assign out_valid    = cnt_q != '0;
	assign token_kind   = head.kind;
	assign start_line   = head.line;
	assign start_column = head.col;
	assign token_length = head.len;
	assign last_of_run  = head.last;

	`ASSERT_IMP(a_fifo_bound, clk, arst_n, 1'b1, cnt_q <= (PTR_W+1)'(FIFO_DEPTH))
	`ASSERT_IMP(a_end_is_last, clk, arst_n, out_valid && token_kind == K_END, last_of_run)
	`ASSERT_IMP(a_len_nonzero, clk, arst_n, out_valid && token_kind != K_END, token_length != 16'd0)

endmodule

// ===== test/testbench.sv =====
module testbench
	import ctl_pkg::*;
();

	// lexer scan states, kept apart from the dut so the model stands alone
	typedef enum logic [2:0] {
		SC_IDLE, SC_IDENT, SC_ZERO, SC_NUM, SC_LEADZ, SC_JUNK, SC_STRING, SC_STRAY
	} scan_t;

	// one row of the directed script; typed rows carry their token by hand
	typedef struct packed {
		logic [7:0]  ch;
		logic        typed;
		kind_t       kind;
		logic [15:0] line;
		logic [15:0] col;
		logic [15:0] len;
	} script_row_t;

	localparam int SCRIPT_LEN  = 26;
	localparam int RANDOM_LEN  = 1500;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 20;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  byte_in;
	logic        out_valid;
	logic        out_stall;
	logic [4:0]  token_kind;
	logic [15:0] start_line;
	logic [15:0] start_column;
	logic [15:0] token_length;
	logic        last_of_run;

	c_subset_token_lexer_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.byte_in      (byte_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.token_kind   (token_kind),
		.start_line   (start_line),
		.start_column (start_column),
		.token_length (token_length),
		.last_of_run  (last_of_run)
	);

	// tokens the dut still owes us, oldest first
	result_t token_queue[$];
	// tokens made by the byte just accepted
	result_t step_tokens[$];
	// source text of the random part
	logic [7:0] source_bytes[$];

	int  error_count    = 0;
	int  tokens_checked = 0;
	int  bytes_sent     = 0;
	int  burst_left     = 0;
	bit  gaps_on        = 1'b1;
	bit  hold_request   = 1'b0;
	bit  hold_done      = 1'b0;

	// lexer model state
	scan_t       lx_mode;
	logic [3:0]  lx_kw;
	logic        lx_letters;
	logic [15:0] lx_line;
	logic [15:0] lx_col;
	logic [15:0] lx_start;
	logic [15:0] lx_len;

	// directed script: keywords, symbols, a string, a leading zero, number junk,
	// a lone slash, a high byte and a string cut off by end of text
	script_row_t script_rows [SCRIPT_LEN] = '{
		'{CH_NUL,   1'b1, K_END,  16'd1, 16'd0,  16'd0},
		'{"r",      1'b0, K_END,  16'd0, 16'd0,  16'd0},
		'{"e",      1'b0, K_END,  16'd0, 16'd0,  16'd0},
		'{"t",      1'b0, K_END,  16'd0, 16'd0,  16'd0},
		'{"u",      1'b0, K_END,  16'd0, 16'd0,  16'd0},
		'{"r",      1'b0, K_END,  16'd0, 16'd0,  16'd0},
		'{"n",      1'b0, K_END,  16'd0, 16'd0,  16'd0},
		'{"(",      1'b0, K_END,  16'd0, 16'd0,  16'd0},
		'{CH_QUOTE, 1'b0, K_END,  16'd0, 16'd0,  16'd0},
		'{"a",      1'b0, K_END,  16'd0, 16'd0,  16'd0},
		'{CH_QUOTE, 1'b1, K_STR,  16'd1, 16'd8,  16'd3},
		'{"0",      1'b0, K_END,  16'd0, 16'd0,  16'd0},
		'{"7",      1'b0, K_END,  16'd0, 16'd0,  16'd0},
		'{"-",      1'b0, K_END,  16'd0, 16'd0,  16'd0},
		'{"9",      1'b0, K_END,  16'd0, 16'd0,  16'd0},
		'{"x",      1'b0, K_END,  16'd0, 16'd0,  16'd0},
		'{CH_SLASH, 1'b0, K_END,  16'd0, 16'd0,  16'd0},
		'{CH_NL,    1'b1, K_ERR,  16'd1, 16'd16, 16'd1},
		'{"i",      1'b0, K_END,  16'd0, 16'd0,  16'd0},
		'{"n",      1'b0, K_END,  16'd0, 16'd0,  16'd0},
		'{"t",      1'b0, K_END,  16'd0, 16'd0,  16'd0},
		'{"=",      1'b0, K_END,  16'd0, 16'd0,  16'd0},
		'{8'hFF,    1'b0, K_END,  16'd0, 16'd0,  16'd0},
		'{",",      1'b0, K_END,  16'd0, 16'd0,  16'd0},
		'{CH_QUOTE, 1'b0, K_END,  16'd0, 16'd0,  16'd0},
		'{CH_NUL,   1'b0, K_END,  16'd0, 16'd0,  16'd0}
	};

	// clock, period of two
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// lexer model
	// ------------------------------------------------------------------

	function automatic logic [15:0] bump(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic logic letter_ch(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic digit_ch(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic blank_ch(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	// single-character symbol lookup; found is low for any other byte
	function automatic kind_t symbol_of(input logic [7:0] c, output logic found);
		found = 1'b1;
		if (c == "+") return K_PLUS;
		if (c == "-") return K_MINUS;
		if (c == "=") return K_EQ;
		if (c == "(") return K_LPAR;
		if (c == ")") return K_RPAR;
		if (c == "{") return K_LBRACE;
		if (c == "}") return K_RBRACE;
		if (c == ",") return K_COMMA;
		if (c == ";") return K_SEMI;
		found = 1'b0;
		return K_ERR;
	endfunction

	function automatic logic ends_token(input logic [7:0] c);
		logic hit;
		void'(symbol_of(c, hit));
		return c == CH_NUL || c == CH_QUOTE || c == CH_SLASH || blank_ch(c) || hit;
	endfunction

	// letter that continues the keyword being matched, zero if none
	function automatic logic [7:0] kw_follow(input logic [3:0] k);
		string w_return;
		string w_int;
		string w_char;
		w_return = "return";
		w_int    = "int";
		w_char   = "char";
		if (k >= KW_R && k < KW_RETURN) return w_return[k - KW_R + 1];
		if (k >= KW_I && k < KW_INT) return w_int[k - KW_I + 1];
		if (k >= KW_C && k < KW_CHAR) return w_char[k - KW_C + 1];
		return 8'h00;
	endfunction

	task automatic lex_reset();
		lx_mode    = SC_IDLE;
		lx_kw      = KW_NONE;
		lx_letters = 1'b1;
		lx_line    = 16'd1;
		lx_col     = 16'd0;
		lx_start   = 16'd0;
		lx_len     = 16'd0;
	endtask

	task automatic emit_token(input kind_t k, input logic [15:0] c, input logic [15:0] n);
		step_tokens.push_back('{kind: k, line: lx_line, col: c, len: n, last: 1'b0});
	endtask

	task automatic close_token(input kind_t k);
		emit_token(k, lx_start, lx_len);
		lx_mode = SC_IDLE;
	endtask

	task automatic open_token(input scan_t m);
		lx_mode  = m;
		lx_start = lx_col;
		lx_len   = 16'd1;
	endtask

	// byte seen with no token in progress
	task automatic lex_idle(input logic [7:0] c);
		logic  hit;
		kind_t sk;
		sk = symbol_of(c, hit);
		if (c == CH_NUL) begin
			emit_token(K_END, lx_col, 16'd0);
			lex_reset();
		end else if (blank_ch(c)) begin
			if (c == CH_NL) begin
				lx_line = bump(lx_line);
				lx_col  = 16'd0;
			end
		end else if (letter_ch(c)) begin
			open_token(SC_IDENT);
			lx_letters = 1'b1;
			lx_kw = (c == "r") ? KW_R : (c == "i") ? KW_I : (c == "c") ? KW_C : KW_NONE;
		end else if (digit_ch(c)) begin
			open_token((c == "0") ? SC_ZERO : SC_NUM);
		end else if (c == CH_QUOTE) begin
			open_token(SC_STRING);
		end else if (hit) begin
			emit_token(sk, lx_col, 16'd1);
		end else begin
			open_token(SC_STRAY);
		end
	endtask

	function automatic kind_t word_kind();
		if (lx_kw == KW_RETURN) return K_RETURN;
		if (lx_kw == KW_INT) return K_INT;
		if (lx_kw == KW_CHAR) return K_CHAR;
		return lx_letters ? K_ID : K_ERR;
	endfunction

	// tokens caused by one byte land in step_tokens
	task automatic lex_byte(input logic [7:0] c);
		logic       redo;
		logic [7:0] nxt;
		redo = 1'b0;
		step_tokens.delete();
		if (c != CH_NUL) lx_col = bump(lx_col);
		case (lx_mode)
			SC_IDENT: begin
				if (ends_token(c)) begin
					close_token(word_kind());
					redo = 1'b1;
				end else begin
					nxt   = kw_follow(lx_kw);
					lx_kw = (nxt != 8'h00 && nxt == c) ? lx_kw + 4'd1 : KW_NONE;
					if (!letter_ch(c)) lx_letters = 1'b0;
					lx_len = bump(lx_len);
				end
			end
			SC_ZERO, SC_NUM: begin
				if (digit_ch(c)) begin
					if (lx_mode == SC_ZERO) lx_mode = SC_LEADZ;
					lx_len = bump(lx_len);
				end else if (ends_token(c)) begin
					close_token(K_NUM);
					redo = 1'b1;
				end else begin
					lx_mode = SC_JUNK;
					lx_len  = bump(lx_len);
				end
			end
			SC_LEADZ: begin
				// leading zero error covers the digits only
				if (digit_ch(c)) begin
					lx_len = bump(lx_len);
				end else begin
					close_token(K_ERR);
					redo = 1'b1;
				end
			end
			SC_JUNK, SC_STRAY: begin
				if (ends_token(c)) begin
					close_token(K_ERR);
					redo = 1'b1;
				end else begin
					lx_len = bump(lx_len);
				end
			end
			SC_STRING: begin
				if (c == CH_QUOTE) begin
					lx_len = bump(lx_len);
					close_token(K_STR);
				end else if (c == CH_NUL || c == CH_NL) begin
					close_token(K_ERR);
					redo = 1'b1;
				end else begin
					lx_len = bump(lx_len);
				end
			end
			default: begin
				lx_mode = SC_IDLE;
				redo    = 1'b1;
			end
		endcase
		if (redo) lex_idle(c);
		if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at token %0d: %s got %0d expected %0d",
			tokens_checked, what, got, want);
		error_count++;
	endtask

	// outputs sampled at the rising edge, before the dut updates them
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (token_queue.size() == 0) begin
				report_mismatch("unexpected token, kind", token_kind, -1);
			end else begin
				want = token_queue.pop_front();
				if (token_kind != want.kind) report_mismatch("kind", token_kind, want.kind);
				if (start_line != want.line) report_mismatch("line", start_line, want.line);
				if (start_column != want.col) report_mismatch("column", start_column, want.col);
				if (token_length != want.len) report_mismatch("length", token_length, want.len);
				if (last_of_run != want.last) report_mismatch("last", last_of_run, want.last);
			end
			tokens_checked++;
		end
	end

	// ------------------------------------------------------------------
	// receiver: stall pattern of its own, plus one long hold
	// ------------------------------------------------------------------

	initial begin
		int mode;
		int span;
		out_stall = 1'b0;
		forever begin
			if (hold_request && !hold_done) begin
				// long hold so the result queue fills and the input stalls
				repeat (HOLD_CYCLES) begin
					@(negedge clk);
					out_stall <= 1'b1;
				end
				hold_done = 1'b1;
			end else begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(20, 200);
				repeat (span) begin
					@(negedge clk);
					case (mode)
						0: out_stall <= 1'b0;
						1: out_stall <= ($urandom_range(0, 4) == 0);
						2: out_stall <= ($urandom_range(0, 9) < 7);
						default: out_stall <= ~out_stall;
					endcase
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// sender
	// ------------------------------------------------------------------

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic offer_byte(input logic [7:0] ch, input logic typed, input result_t fixed);
		int gap;
		if (gaps_on) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 48);
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			burst_left--;
		end
		in_valid <= 1'b1;
		byte_in  <= ch;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		lex_byte(ch);
		if (typed) begin
			token_queue.push_back(fixed);
		end else begin
			foreach (step_tokens[i]) token_queue.push_back(step_tokens[i]);
		end
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) source_bytes.push_back(s[i]);
	endtask

	function automatic logic [7:0] rand_letter();
		int r;
		r = $urandom_range(0, 51);
		return (r < 26) ? 8'(8'h61 + r) : 8'(8'h41 + r - 26);
	endfunction

	function automatic string rand_keyword();
		case ($urandom_range(0, 2))
			0: return "return";
			1: return "int";
			default: return "char";
		endcase
	endfunction

	// random text: mostly well-formed tokens with random content, some noise
	task automatic build_program();
		int    r;
		int    n;
		string w;
		logic [7:0] b;
		while (source_bytes.size() < RANDOM_LEN) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				push_text(rand_keyword());
			end else if (r < 30) begin
				// plain words, near misses of keywords among them
				case ($urandom_range(0, 2))
					0: begin
						w = rand_keyword();
						push_text(w.substr(0, $urandom_range(0, w.len() - 2)));
					end
					1: begin
						push_text(rand_keyword());
						repeat ($urandom_range(1, 3)) source_bytes.push_back(rand_letter());
					end
					default: repeat ($urandom_range(1, 8)) source_bytes.push_back(rand_letter());
				endcase
			end else if (r < 42) begin
				case ($urandom_range(0, 5))
					0: source_bytes.push_back("0");
					1: begin
						// leading zero followed by digits
						source_bytes.push_back("0");
						repeat ($urandom_range(1, 3))
							source_bytes.push_back(8'(8'h30 + $urandom_range(0, 9)));
					end
					default: begin
						source_bytes.push_back(8'(8'h30 + $urandom_range(1, 9)));
						repeat ($urandom_range(0, 4))
							source_bytes.push_back(8'(8'h30 + $urandom_range(0, 9)));
					end
				endcase
			end else if (r < 50) begin
				source_bytes.push_back(CH_QUOTE);
				n = $urandom_range(0, 6);
				for (int i = 0; i < n; i++) begin
					b = 8'($urandom_range(1, 255));
					if (b == CH_QUOTE || b == CH_NL) b = "q";
					source_bytes.push_back(b);
				end
				source_bytes.push_back(CH_QUOTE);
			end else if (r < 75) begin
				w = "+-=(){},;";
				source_bytes.push_back(w[$urandom_range(0, 8)]);
			end else if (r < 80) begin
				// word that may take digits or other junk, an error when it does
				source_bytes.push_back(rand_letter());
				repeat ($urandom_range(1, 4)) begin
					case ($urandom_range(0, 3))
						0: source_bytes.push_back(rand_letter());
						1: source_bytes.push_back(8'(8'h30 + $urandom_range(0, 9)));
						2: source_bytes.push_back("_");
						default: source_bytes.push_back(8'($urandom_range(128, 255)));
					endcase
				end
			end else if (r < 84) begin
				source_bytes.push_back(8'(8'h30 + $urandom_range(1, 9)));
				repeat ($urandom_range(1, 3)) source_bytes.push_back(rand_letter());
			end else if (r < 88) begin
				source_bytes.push_back(CH_SLASH);
			end else if (r < 92) begin
				w = "@#*_$%!?";
				if ($urandom_range(0, 1)) source_bytes.push_back(w[$urandom_range(0, 7)]);
				else source_bytes.push_back(8'($urandom_range(128, 255)));
				repeat ($urandom_range(0, 2)) source_bytes.push_back(rand_letter());
			end else if (r < 94) begin
				// string cut off by a newline
				source_bytes.push_back(CH_QUOTE);
				repeat ($urandom_range(0, 4)) source_bytes.push_back(rand_letter());
				source_bytes.push_back(CH_NL);
			end else if (r < 96) begin
				source_bytes.push_back(CH_NUL);
			end else begin
				source_bytes.push_back(8'($urandom_range(1, 255)));
			end
			// separator, or none so neighbors run together
			r = $urandom_range(0, 99);
			if (r < 40) source_bytes.push_back(CH_SPACE);
			else if (r < 50) source_bytes.push_back(CH_NL);
			else if (r < 55) source_bytes.push_back(8'($urandom_range(9, 13)));
		end
		source_bytes.push_back(CH_NUL);
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------

	initial begin
		result_t fixed;
		result_t none;
		int      waited;
		none     = '0;
		in_valid = 1'b0;
		byte_in  = 8'h00;
		arst_n   = 1'b0;
		lex_reset();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed script
		foreach (script_rows[i]) begin
			fixed = '{kind: script_rows[i].kind, line: script_rows[i].line,
				col: script_rows[i].col, len: script_rows[i].len, last: 1'b1};
			offer_byte(script_rows[i].ch, script_rows[i].typed, fixed);
		end

		// random text, with the receiver holding off early on
		hold_request = 1'b1;
		build_program();
		foreach (source_bytes[i]) offer_byte(source_bytes[i], 1'b0, none);
		in_valid <= 1'b0;

		// drain, then watch for anything stray
		waited = 0;
		while (token_queue.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		if (token_queue.size() != 0) report_mismatch("tokens left over", token_queue.size(), 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("sent %0d bytes (directed script and random text) and checked %0d tokens",
			bytes_sent, tokens_checked);
		$display("the receiver held off for %0d cycles once to back up the input", HOLD_CYCLES);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// overall time limit
	initial begin
		#4000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
